// File: rtl/sparse_triplet_transpose_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sparse triplet transpose block
// Each macro needs clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_TRANSPOSE_DEFINES_SVH
`define SPARSE_TRIPLET_TRANSPOSE_DEFINES_SVH

// Same-cycle implication.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// Shared constants, types and helpers of the sparse triplet transpose block.
// ---------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned MAX_COLS    = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned COL_W       = 3;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned TRIP_W      = ROW_W + COL_W + VALUE_W;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = DIM_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EMPTY,
    ST_READ,
    ST_CHECK
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic rd_en;
    logic advance;
    logic out_load_trip;
    logic out_load_empty;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic matrix_end;
    logic empty_end;
    logic match;
    logic last_emit;
    logic out_free;
  } status_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// File: rtl/sparse_triplet_transpose.sv
// ---------------------------------------------------------------------------
// sparse_triplet_transpose
// Load: one element beat per cycle; results only follow the last element.
// Scan: per column and stored triplet, a registered store read, then a compare,
//   until the last triplet is emitted; output stalls hold the compare; all-zero: ST_EMPTY.
// The single store read port sets the scan rate; no element is taken during the scan.
// Reset clears shape (8x8), load position, count and output valid; store contents stay undefined.
// ---------------------------------------------------------------------------
module sparse_triplet_transpose import stt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // element input, one beat per matrix element in row-major order
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_W-1:0]    element_value_i,
  // transposed triplet output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic [VALUE_W-1:0]    out_value_o,
  output logic [CNT_W-1:0]      nonzero_count_o,
  output logic                  is_empty_o,
  output logic                  is_last_o
);

  // The controller sequences three phases:
  //   load  - take one element beat per cycle, store each nonzero as a triplet
  //   scan  - for every column in ascending order, read each stored triplet
  //           and push matching ones, row and column swapped, into the
  //           output register; the run ends with the last stored triplet
  //           emitted, which also carries is_last
  //   empty - an all-zero matrix gives a single flagged beat
  // The output register lets the last result of a run wait while the next
  // matrix already loads.

  cmd_t    cmd;
  status_t status;

  stt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  stt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .element_value_i(element_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .nonzero_count_o(nonzero_count_o),
    .is_empty_o     (is_empty_o),
    .is_last_o      (is_last_o)
  );

endmodule

// File: rtl/stt_ram.sv
// ---------------------------------------------------------------------------
// stt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stt_ctrl.sv
// ---------------------------------------------------------------------------
// stt_ctrl
// Sequencer: load elements, then run the column-by-triplet scan or emit the empty beat.
// ---------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.matrix_end) begin
          if (status_i.empty_end) begin
            state_d = ST_EMPTY;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.out_load_empty = 1'b1;
          state_d              = ST_LOAD;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.match) begin
          // hold the read data until the output register frees up
          if (status_i.out_free) begin
            cmd_o.out_load_trip = 1'b1;
            cmd_o.advance       = 1'b1;
            if (status_i.last_emit) begin
              cmd_o.finish = 1'b1;
              state_d      = ST_LOAD;
            end else begin
              state_d = ST_READ;
            end
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_READ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/stt_dp.sv
// ---------------------------------------------------------------------------
// stt_dp
// Shape registers, load counters, triplet store, scan counters, output register.
// ---------------------------------------------------------------------------
`include "sparse_triplet_transpose_defines.svh"

module stt_dp import stt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [VALUE_W-1:0]    element_value_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic [VALUE_W-1:0]    out_value_o,
  output logic [CNT_W-1:0]      nonzero_count_o,
  output logic                  is_empty_o,
  output logic                  is_last_o
);

  logic [DIM_W-1:0]   num_rows_q, num_cols_q;
  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [ROW_W-1:0]   load_row_q;
  logic [COL_W-1:0]   load_col_q;
  logic [CNT_W-1:0]   count_q;
  logic [ADDR_W-1:0]  scan_idx_q;
  logic [COL_W-1:0]   scan_col_q;
  logic [CNT_W-1:0]   emit_cnt_q;
  logic               row_end, nonzero, store_full, wr_en;
  logic [TRIP_W-1:0]  rd_data;
  logic [ROW_W-1:0]   rd_row;
  logic [COL_W-1:0]   rd_col;
  logic [VALUE_W-1:0] rd_value;

  logic               out_valid_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [CNT_W-1:0]   out_count_q;
  logic               out_empty_q, out_last_q;

  // Shape registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(MAX_ROWS);
      num_cols_q <= DIM_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_eff = clamp_dim(num_rows_q, DIM_W'(MAX_ROWS));
  assign cols_eff = clamp_dim(num_cols_q, DIM_W'(MAX_COLS));

  assign row_end    = ({1'b0, load_col_q} + DIM_W'(1)) >= cols_eff;
  assign nonzero    = element_value_i != '0;
  assign store_full = count_q >= CNT_W'(STORE_DEPTH);
  assign wr_en      = cmd_i.accept && nonzero && !store_full;

  // Load counters and nonzero count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
      count_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (status_o.matrix_end) begin
          load_row_q <= '0;
          load_col_q <= '0;
        end else if (row_end) begin
          load_col_q <= '0;
          load_row_q <= load_row_q + ROW_W'(1);
        end else begin
          load_col_q <= load_col_q + COL_W'(1);
        end
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.finish) begin
        count_q <= '0;
      end
    end
  end

  stt_ram #(
    .Width(TRIP_W),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i({load_row_q, load_col_q, element_value_i}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(scan_idx_q),
    .rdata_o(rd_data)
  );

  assign {rd_row, rd_col, rd_value} = rd_data;

  // Scan counters: column outer, triplet index inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      scan_col_q <= '0;
      emit_cnt_q <= '0;
    end else if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      scan_col_q <= '0;
      emit_cnt_q <= '0;
    end else begin
      if (cmd_i.advance) begin
        if (({1'b0, scan_idx_q} + CNT_W'(1)) >= count_q) begin
          scan_idx_q <= '0;
          scan_col_q <= scan_col_q + COL_W'(1);
        end else begin
          scan_idx_q <= scan_idx_q + ADDR_W'(1);
        end
      end
      if (cmd_i.out_load_trip) begin
        emit_cnt_q <= emit_cnt_q + CNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_trip || cmd_i.out_load_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_trip) begin
      out_row_q   <= scan_col_q;
      out_col_q   <= rd_row;
      out_value_q <= rd_value;
      out_count_q <= count_q;
      out_empty_q <= 1'b0;
      out_last_q  <= status_o.last_emit;
    end else if (cmd_i.out_load_empty) begin
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_count_q <= '0;
      out_empty_q <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  assign status_o.matrix_end = row_end &&
                               (({1'b0, load_row_q} + DIM_W'(1)) >= rows_eff);
  assign status_o.empty_end  = (count_q == '0) && !nonzero;
  assign status_o.match      = rd_col == scan_col_q;
  assign status_o.last_emit  = (emit_cnt_q + CNT_W'(1)) == count_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign out_value_o     = out_value_q;
  assign nonzero_count_o = out_count_q;
  assign is_empty_o      = out_empty_q;
  assign is_last_o       = out_last_q;

  `STT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(STORE_DEPTH), "count past store depth")
  `STT_ASSERT_IMP(a_load_needs_room, cmd_i.out_load_trip || cmd_i.out_load_empty, status_o.out_free, "output register overwritten")
  `STT_ASSERT_IMP(a_no_rw_clash, wr_en, !cmd_i.rd_en, "store written during scan")
  `STT_ASSERT_IMP(a_emit_bound, cmd_i.out_load_trip, emit_cnt_q < count_q, "more results than triplets")
  `STT_ASSERT_NXT(a_finish_clears, cmd_i.finish, count_q == '0, "count not cleared after run")

endmodule
